// ----- hdl/qrs_pkg.sv -----
package qrs_pkg;

	// Field widths
	localparam int IN_W = 32;
	localparam int OUT_W = 48;
	localparam int OUT_FRAC = 24;
	localparam int SQRT_EXTRA = 16;

	// Discriminant and square root
	localparam int D_W = 66;
	localparam int X_W = D_W + 2 * SQRT_EXTRA;
	localparam int ROOT_W = X_W / 2;
	localparam int REM_W = ROOT_W + 3;

	// Numerators and divider
	localparam int NUM_W = ROOT_W + 2;
	localparam int MAG_W = NUM_W - 1;
	localparam int Q_W = OUT_W;
	localparam int DIV_LAT = Q_W + 2;

	typedef enum logic [2:0] {
		CASE_LINEAR = 3'd0,
		CASE_CONTRA = 3'd1,
		CASE_IDENT  = 3'd2,
		CASE_TWO    = 3'd3,
		CASE_DOUBLE = 3'd4,
		CASE_NONE   = 3'd5
	} qrs_case_t;

	// Coefficients and case travelling beside the square root
	typedef struct packed {
		qrs_case_t              code;
		logic signed [IN_W-1:0] a;
		logic signed [IN_W-1:0] b;
		logic signed [IN_W-1:0] c;
	} qrs_side_t;

	// Result control travelling beside the dividers
	typedef struct packed {
		qrs_case_t code;
		logic      neg1;
		logic      neg2;
		logic      neg3;
		logic      b_neg;
	} qrs_ctl_t;

	typedef struct packed {
		logic [OUT_W-1:0] val;
		logic             sat;
	} qrs_res_t;

	function automatic logic [IN_W-1:0] mag32(input logic signed [IN_W-1:0] v);
		logic [IN_W-1:0] u;
		u = v;
		return v[IN_W-1] ? (~u + 1'b1) : u;
	endfunction

	function automatic logic [MAG_W-1:0] mag_num(input logic signed [NUM_W-1:0] v);
		logic [NUM_W-1:0] u;
		logic [NUM_W-1:0] m;
		u = v;
		m = v[NUM_W-1] ? (~u + 1'b1) : u;
		return m[MAG_W-1:0];
	endfunction

	// Saturate a quotient magnitude and apply its sign
	function automatic qrs_res_t sat_val(input logic [Q_W-1:0] q, input logic ovf,
		input logic neg);
		logic [OUT_W-1:0] limit;
		logic [OUT_W-1:0] m;
		qrs_res_t r;
		limit = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		r.sat = ovf | (q > limit);
		m = r.sat ? limit : q;
		r.val = neg ? (~m + 1'b1) : m;
		return r;
	endfunction

endpackage

// ----- hdl/quadratic_root_solver_core.sv -----
// Quadratic root solver: takes Q16.16 coefficients a, b, c and returns a case code
// with classical and cancellation-free roots in Q24.24, saturated to 48 bits with an
// overflow flag. Fully pipelined: one coefficient word is accepted every cycle while
// the output is not held; each word passes through the product and discriminant
// registers, a 49-stage bit-per-stage square root, 1 numerator stage, three parallel
// 50-stage bit-per-stage dividers and 1 output register. A result that is not
// taken stalls the whole pipeline in place; nothing is dropped.
module quadratic_root_solver_core import qrs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [IN_W-1:0]  coef_quad,
	input  logic signed [IN_W-1:0]  coef_lin,
	input  logic signed [IN_W-1:0]  coef_const,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              case_code,
	output logic signed [OUT_W-1:0] classic_root_plus,
	output logic signed [OUT_W-1:0] classic_root_minus,
	output logic signed [OUT_W-1:0] stable_root_first,
	output logic signed [OUT_W-1:0] stable_root_second,
	output logic                    overflow_flag
);

	logic en;

	logic           fr_vld;
	logic [D_W-1:0] fr_disc;
	qrs_side_t      fr_side;

	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	qrs_side_t         sq_side;

	logic                    v_s3;
	logic signed [NUM_W-1:0] np_s3, nm_s3;
	qrs_side_t               side_s3;

	logic                    out_valid_q;
	qrs_case_t               code_q;
	logic [OUT_W-1:0]        plus_q, minus_q, first_q, second_q;
	logic                    ovf_q;

	// Pipeline advances unless the output word is held
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	qrs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.a       (coef_quad),
		.b       (coef_lin),
		.c       (coef_const),
		.out_vld (fr_vld),
		.disc    (fr_disc),
		.side    (fr_side)
	);

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fr_vld),
		.rad      (fr_disc),
		.side_in  (fr_side),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// Classical numerators -b*2^16 +/- sqrt
	logic signed [NUM_W-1:0] bs_w, s_w;

	assign bs_w = {{(NUM_W-IN_W-SQRT_EXTRA){sq_side.b[IN_W-1]}}, sq_side.b,
		{SQRT_EXTRA{1'b0}}};
	assign s_w  = {{(NUM_W-ROOT_W){1'b0}}, sq_root};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s3   <= s_w - bs_w;
			nm_s3   <= -bs_w - s_w;
			side_s3 <= sq_side;
		end
	end

	// Divider operand selection per case
	logic [IN_W-1:0]         abs_a, abs_b, abs_c;
	logic signed [NUM_W-1:0] first;
	logic [MAG_W-1:0]        num1, den1, num2, den2, num3, den3;
	qrs_ctl_t                ctl;

	assign abs_a = mag32(side_s3.a);
	assign abs_b = mag32(side_s3.b);
	assign abs_c = mag32(side_s3.c);
	assign first = side_s3.b[IN_W-1] ? np_s3 : nm_s3;

	always_comb begin
		num1      = '0;
		den1      = MAG_W'(1);
		num2      = '0;
		den2      = MAG_W'(1);
		num3      = '0;
		den3      = MAG_W'(1);
		ctl.code  = side_s3.code;
		ctl.neg1  = 1'b0;
		ctl.neg2  = 1'b0;
		ctl.neg3  = 1'b0;
		ctl.b_neg = side_s3.b[IN_W-1];
		unique case (side_s3.code)
			CASE_LINEAR: begin
				num1     = MAG_W'(abs_c);
				den1     = MAG_W'(abs_b);
				ctl.neg1 = side_s3.c[IN_W-1] == side_s3.b[IN_W-1];
			end
			CASE_DOUBLE: begin
				num1     = MAG_W'(abs_b);
				den1     = MAG_W'({abs_a, 1'b0});
				ctl.neg1 = side_s3.b[IN_W-1] == side_s3.a[IN_W-1];
			end
			CASE_TWO: begin
				num1     = mag_num(np_s3);
				den1     = MAG_W'({abs_a, {(SQRT_EXTRA+1){1'b0}}});
				ctl.neg1 = np_s3[NUM_W-1] != side_s3.a[IN_W-1];
				num2     = mag_num(nm_s3);
				den2     = MAG_W'({abs_a, {(SQRT_EXTRA+1){1'b0}}});
				ctl.neg2 = nm_s3[NUM_W-1] != side_s3.a[IN_W-1];
				num3     = MAG_W'({abs_c, {(SQRT_EXTRA+1){1'b0}}});
				den3     = mag_num(first);
				ctl.neg3 = side_s3.c[IN_W-1] != first[NUM_W-1];
			end
			default: begin
			end
		endcase
	end

	logic           d1_vld, d2_vld, d3_vld;
	logic [Q_W-1:0] q1, q2, q3;
	logic           o1, o2, o3;

	qrs_div u_div_plus (
		.clk (clk), .arst_n (arst_n), .en (en), .in_vld (v_s3),
		.num (num1), .den (den1), .out_vld (d1_vld), .quo (q1), .ovf (o1)
	);

	qrs_div u_div_minus (
		.clk (clk), .arst_n (arst_n), .en (en), .in_vld (v_s3),
		.num (num2), .den (den2), .out_vld (d2_vld), .quo (q2), .ovf (o2)
	);

	qrs_div u_div_second (
		.clk (clk), .arst_n (arst_n), .en (en), .in_vld (v_s3),
		.num (num3), .den (den3), .out_vld (d3_vld), .quo (q3), .ovf (o3)
	);

	// Control delay matching the dividers
	qrs_ctl_t ctl_s [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0] <= ctl;
			for (int i = 1; i < DIV_LAT; i++) ctl_s[i] <= ctl_s[i-1];
		end
	end

	// Saturation, sign and case gating into the output register
	qrs_res_t r1, r2, r3;
	qrs_ctl_t cd;
	logic     res_vld;

	assign cd      = ctl_s[DIV_LAT-1];
	assign r1      = sat_val(q1, o1, cd.neg1);
	assign r2      = sat_val(q2, o2, cd.neg2);
	assign r3      = sat_val(q3, o3, cd.neg3);
	assign res_vld = d1_vld && d2_vld && d3_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= res_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_q   <= cd.code;
			plus_q   <= '0;
			minus_q  <= '0;
			first_q  <= '0;
			second_q <= '0;
			ovf_q    <= 1'b0;
			unique case (cd.code)
				CASE_LINEAR, CASE_DOUBLE: begin
					plus_q <= r1.val;
					ovf_q  <= r1.sat;
				end
				CASE_TWO: begin
					plus_q   <= r1.val;
					minus_q  <= r2.val;
					first_q  <= cd.b_neg ? r1.val : r2.val;
					second_q <= r3.val;
					ovf_q    <= r1.sat | r2.sat | r3.sat;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign case_code          = code_q;
	assign classic_root_plus  = plus_q;
	assign classic_root_minus = minus_q;
	assign stable_root_first  = first_q;
	assign stable_root_second = second_q;
	assign overflow_flag      = ovf_q;

endmodule

// ----- hdl/qrs_front.sv -----
module qrs_front import qrs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic signed [IN_W-1:0] a,
	input  logic signed [IN_W-1:0] b,
	input  logic signed [IN_W-1:0] c,
	output logic                   out_vld,
	output logic [D_W-1:0]         disc,
	output qrs_side_t              side
);

	logic                   v_s1;
	logic signed [IN_W-1:0] a_s1, b_s1, c_s1;
	logic [2*IN_W-1:0]      pbb_s1, pac_s1;

	logic                   v_s2;
	logic [D_W-1:0]         d_s2;
	qrs_side_t              side_s2;

	logic [D_W-1:0] p, q4, dn;
	qrs_case_t      code;

	// Stage 1: squares and products of magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a;
			b_s1   <= b;
			c_s1   <= c;
			pbb_s1 <= mag32(b) * mag32(b);
			pac_s1 <= mag32(a) * mag32(c);
		end
	end

	// Stage 2: discriminant and case decision
	assign p  = {2'b00, pbb_s1};
	assign q4 = {pac_s1, 2'b00};

	always_comb begin
		dn   = '0;
		code = CASE_NONE;
		if (a_s1 == '0) begin
			if (b_s1 != '0) code = CASE_LINEAR;
			else if (c_s1 != '0) code = CASE_CONTRA;
			else code = CASE_IDENT;
		end else if (a_s1[IN_W-1] == c_s1[IN_W-1]) begin
			if (p > q4) begin
				code = CASE_TWO;
				dn   = p - q4;
			end else if (p == q4) begin
				code = CASE_DOUBLE;
			end
		end else begin
			dn   = p + q4;
			code = (dn == '0) ? CASE_DOUBLE : CASE_TWO;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2         <= dn;
			side_s2.code <= code;
			side_s2.a    <= a_s1;
			side_s2.b    <= b_s1;
			side_s2.c    <= c_s1;
		end
	end

	assign out_vld = v_s2;
	assign disc    = d_s2;
	assign side    = side_s2;

endmodule

// ----- hdl/qrs_sqrt.sv -----
module qrs_sqrt import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [D_W-1:0]    rad,
	input  qrs_side_t         side_in,
	output logic              out_vld,
	output logic [ROOT_W-1:0] root,
	output qrs_side_t         side_out
);

	// One root bit per stage, most significant first
	logic              vld_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [X_W-1:0]    x_s    [ROOT_W];
	qrs_side_t         side_s [ROOT_W];

	genvar k;
	for (k = 0; k < ROOT_W; k++) begin : g_stage
		logic              vld_p;
		logic [REM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [X_W-1:0]    x_p;
		qrs_side_t         side_p;
		logic [REM_W-1:0]  cur, trial;

		if (k == 0) begin : g_first
			assign vld_p  = in_vld;
			assign rem_p  = '0;
			assign root_p = '0;
			assign x_p    = {rad, {(2*SQRT_EXTRA){1'b0}}};
			assign side_p = side_in;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign x_p    = x_s[k-1];
			assign side_p = side_s[k-1];
		end

		// Bring down the next radicand pair, try root*4+1
		assign cur   = {rem_p[REM_W-3:0], x_p[X_W-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_s[k]  <= cur - trial;
					root_s[k] <= {root_p[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cur;
					root_s[k] <= {root_p[ROOT_W-2:0], 1'b0};
				end
				x_s[k]    <= {x_p[X_W-3:0], 2'b00};
				side_s[k] <= side_p;
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign root     = root_s[ROOT_W-1];
	assign side_out = side_s[ROOT_W-1];

endmodule

// ----- hdl/qrs_div.sv -----
module qrs_div import qrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [MAG_W-1:0] num,
	input  logic [MAG_W-1:0] den,
	output logic             out_vld,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	// Quotient is floor(num * 2^OUT_FRAC / den), Q_W bits, overflow flagged
	localparam int SH = Q_W - OUT_FRAC;

	logic             vld_s0;
	logic [MAG_W-1:0] num_s0, den_s0;

	logic             vld_s  [Q_W+1];
	logic [MAG_W-1:0] rem_s  [Q_W+1];
	logic [MAG_W-1:0] num_s  [Q_W+1];
	logic [MAG_W-1:0] den_s  [Q_W+1];
	logic [Q_W-1:0]   q_s    [Q_W+1];
	logic             ovf_s  [Q_W+1];

	// Operand capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else if (en) vld_s0 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s0 <= num;
			den_s0 <= den;
		end
	end

	// Range check and initial partial remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= vld_s0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= {{SH{1'b0}}, num_s0} >= {den_s0, {SH{1'b0}}};
			rem_s[0] <= num_s0 >> SH;
			num_s[0] <= num_s0;
			den_s[0] <= den_s0;
			q_s[0]   <= '0;
		end
	end

	// One quotient bit per stage
	genvar k;
	for (k = 1; k <= Q_W; k++) begin : g_stage
		logic             xbit;
		logic [MAG_W:0]   t;
		logic [MAG_W:0]   dd;

		if (Q_W - k >= OUT_FRAC) begin : g_hi
			assign xbit = num_s[k-1][Q_W-k-OUT_FRAC];
		end else begin : g_lo
			assign xbit = 1'b0;
		end

		assign t  = {rem_s[k-1], xbit};
		assign dd = {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= dd) begin
					rem_s[k] <= MAG_W'(t - dd);
					q_s[k]   <= {q_s[k-1][Q_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= t[MAG_W-1:0];
					q_s[k]   <= {q_s[k-1][Q_W-2:0], 1'b0};
				end
				num_s[k] <= num_s[k-1];
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign out_vld = vld_s[Q_W];
	assign quo     = q_s[Q_W];
	assign ovf     = ovf_s[Q_W];

endmodule
